/* hw/rtl/sspd_pkg.sv */
// Shared constants, codes, types and structs of the servo speed-to-duty core.
package sspd_pkg;

    localparam int MODE_W      = 3;
    localparam int SPEED_W     = 8;
    localparam int PULSE_W     = 12;
    localparam int DUTY_W      = 16;
    localparam int ELAPSED_W   = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_W       = 12;

    localparam int RES_BITS    = 16;
    localparam int PERIOD_US   = 20000;
    localparam int MOVE_MS     = 1000;

    localparam int unsigned FULL_SCALE = (32'd1 << RES_BITS) - 32'd1;

    localparam int SPEED_LIM   = 100;
    localparam int MAP_DIV     = 100;
    localparam int MAG_W       = 7;

    localparam int B_W         = (RES_BITS > MAG_W) ? RES_BITS : MAG_W;
    localparam int PROD_W      = PULSE_W + B_W;
    localparam int DIV_W       = ($clog2(PERIOD_US + 1) > $clog2(MAP_DIV + 1)) ?
                                 $clog2(PERIOD_US + 1) : $clog2(MAP_DIV + 1);
    localparam int CNT_W       = $clog2(PROD_W);
    localparam int RAW_W       = PULSE_W + 2;

    localparam logic [ELAPSED_W-1:0] MOVE_MS_CNT = ELAPSED_W'(MOVE_MS);

    localparam logic [MODE_W-1:0] MODE_SET   = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_STOP  = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_RAISE = MODE_W'(2);
    localparam logic [MODE_W-1:0] MODE_LOWER = MODE_W'(3);
    localparam logic [MODE_W-1:0] MODE_TICK  = MODE_W'(4);

    localparam logic [CFG_IDX_W-1:0] CFG_STOP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX  = CFG_IDX_W'(2);

    localparam logic [CFG_W-1:0] STOP_RESET = CFG_W'(1500);
    localparam logic [CFG_W-1:0] MIN_RESET  = CFG_W'(1000);
    localparam logic [CFG_W-1:0] MAX_RESET  = CFG_W'(2000);

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } md_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP_GO,
        ST_MAP_WAIT,
        ST_DUTY_GO,
        ST_DUTY_WAIT,
        ST_EMIT
    } ctl_state_t;

    typedef struct packed {
        logic                start;
        logic [PULSE_W-1:0]  a;
        logic [B_W-1:0]      b;
        logic [DIV_W-1:0]    d;
    } md_req_t;

    typedef struct packed {
        logic                done;
        logic [PROD_W-1:0]   q;
    } md_rsp_t;

endpackage

/* hw/rtl/sspd_cmd_if.sv */
// Command channel: mode and speed with valid/ready handshake.
interface sspd_cmd_if;
    logic                                  valid;
    logic                                  ready;
    logic [sspd_pkg::MODE_W-1:0]           mode;
    logic signed [sspd_pkg::SPEED_W-1:0]   speed;

    modport source (output valid, output mode, output speed, input ready);
    modport sink   (input valid, input mode, input speed, output ready);
endinterface

/* hw/rtl/sspd_res_if.sv */
// Result channel: duty word, pulse width and timed-move flag with valid/ready handshake.
interface sspd_res_if;
    logic                            valid;
    logic                            ready;
    logic [sspd_pkg::DUTY_W-1:0]     duty;
    logic [sspd_pkg::PULSE_W-1:0]    pulse_us;
    logic                            timed_active;

    modport source (output valid, output duty, output pulse_us, output timed_active,
                    input ready);
    modport sink   (input valid, input duty, input pulse_us, input timed_active,
                    output ready);
endinterface

/* hw/rtl/sspd_muldiv.sv */
// Bit-serial multiply followed by restoring divide: q = a * b / d.
module sspd_muldiv (
    input  logic              clk,
    input  logic              rst_n,
    input  sspd_pkg::md_req_t req,
    output sspd_pkg::md_rsp_t rsp
);

    sspd_pkg::md_state_t state_reg, state_next;

    logic [sspd_pkg::PULSE_W-1:0] a_reg, a_next;
    logic [sspd_pkg::B_W-1:0]     b_reg, b_next;
    logic [sspd_pkg::DIV_W-1:0]   d_reg, d_next;
    logic [sspd_pkg::PROD_W-1:0]  acc_reg, acc_next;
    logic [sspd_pkg::DIV_W-1:0]   rem_reg, rem_next;
    logic [sspd_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                         done_reg, done_next;

    logic [sspd_pkg::DIV_W:0]     shifted;
    logic [sspd_pkg::DIV_W:0]     trial;
    logic                         ge;
    logic [sspd_pkg::PROD_W-1:0]  addend;

    assign shifted = {rem_reg, acc_reg[sspd_pkg::PROD_W-1]};
    assign ge      = (shifted >= {1'b0, d_reg});
    assign trial   = shifted - {1'b0, d_reg};
    assign addend  = a_reg[sspd_pkg::PULSE_W-1] ?
                     {{(sspd_pkg::PROD_W - sspd_pkg::B_W){1'b0}}, b_reg} : '0;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sspd_pkg::MD_IDLE:
            begin
                if (req.start)
                begin
                    state_next = sspd_pkg::MD_MUL;
                end
            end
            sspd_pkg::MD_MUL:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = sspd_pkg::MD_DIV;
                end
            end
            sspd_pkg::MD_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = sspd_pkg::MD_IDLE;
                end
            end
            default:
            begin
                state_next = sspd_pkg::MD_IDLE;
            end
        endcase
    end

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        d_next    = d_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        unique case (state_reg)
            sspd_pkg::MD_IDLE:
            begin
                if (req.start)
                begin
                    a_next   = req.a;
                    b_next   = req.b;
                    d_next   = req.d;
                    acc_next = '0;
                    rem_next = '0;
                    cnt_next = sspd_pkg::CNT_W'(sspd_pkg::PULSE_W - 1);
                end
            end
            sspd_pkg::MD_MUL:
            begin
                acc_next = {acc_reg[sspd_pkg::PROD_W-2:0], 1'b0} + addend;
                a_next   = {a_reg[sspd_pkg::PULSE_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    cnt_next = sspd_pkg::CNT_W'(sspd_pkg::PROD_W - 1);
                    rem_next = '0;
                end
            end
            sspd_pkg::MD_DIV:
            begin
                rem_next  = ge ? trial[sspd_pkg::DIV_W-1:0] : shifted[sspd_pkg::DIV_W-1:0];
                acc_next  = {acc_reg[sspd_pkg::PROD_W-2:0], ge};
                cnt_next  = cnt_reg - 1'b1;
                done_next = (cnt_reg == '0);
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rsp.done = done_reg;
        rsp.q    = acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sspd_pkg::MD_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        d_reg   <= d_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == sspd_pkg::MD_IDLE))
        else $error("muldiv done outside idle");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> (state_reg == sspd_pkg::MD_IDLE))
        else $error("muldiv started while busy");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sspd_pkg::MD_DIV) |-> (rem_reg < d_reg))
        else $error("divider remainder out of range");

endmodule

/* hw/rtl/servo_speed_to_pwm_duty_core.sv */
// Servo speed-to-duty core: command decode, timed move, pulse map and duty scaling.
//
//   port    dir  payload                          handshake
//   cmd     in   mode[2:0], speed[7:0] signed     valid/ready
//   res     out  duty[15:0], pulse_us[11:0], t_a  valid/ready
//   cfg     in   cfg_index[1:0], cfg_data[11:0]   cfg_we, no stall
//
// One serial multiply-divide unit retires one bit per cycle, multiplying and then dividing in each pass.
// Nonzero set speed, raise and lower take two passes (pulse map, then duty scaling),
// zero set speed, stop and an expiring tick one (duty scaling), other ticks and unknown modes none.
// Reset loads the default pulse widths and disarms the timer. A result waits in the output
// register while the next command is taken; a second result stalls until that one leaves.
module servo_speed_to_pwm_duty_core (
    input  logic                          clk,
    input  logic                          rst_n,
    sspd_cmd_if.sink                      cmd,
    sspd_res_if.source                    res,
    input  logic                          cfg_we,
    input  logic [sspd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sspd_pkg::CFG_W-1:0]    cfg_data
);

    sspd_pkg::ctl_state_t state_reg, state_next;

    logic [sspd_pkg::PULSE_W-1:0]   stop_reg, min_reg, max_reg;
    logic                           armed_reg, armed_next;
    logic [sspd_pkg::ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [sspd_pkg::PULSE_W-1:0]   opa_reg, opa_next;
    logic [sspd_pkg::B_W-1:0]       opb_reg, opb_next;
    logic                           use_period_reg, use_period_next;
    logic                           neg_reg, neg_next;
    logic [sspd_pkg::PULSE_W-1:0]   base_reg, base_next;
    logic [sspd_pkg::PULSE_W-1:0]   pulse_reg, pulse_next;
    logic [sspd_pkg::DUTY_W-1:0]    duty_reg, duty_next;
    logic                           out_valid_reg, out_valid_next;
    logic [sspd_pkg::DUTY_W-1:0]    out_duty_reg, out_duty_next;
    logic [sspd_pkg::PULSE_W-1:0]   out_pulse_reg, out_pulse_next;
    logic                           out_active_reg, out_active_next;

    sspd_pkg::md_req_t md_req;
    sspd_pkg::md_rsp_t md_rsp;

    logic                               cmd_fire;
    logic                               out_free;
    logic signed [sspd_pkg::SPEED_W-1:0] spd_clamped;
    logic signed [sspd_pkg::SPEED_W-1:0] spd_eff;
    logic signed [sspd_pkg::SPEED_W-1:0] spd_shift;
    logic                               spd_pos;
    logic                               spd_zero;
    logic signed [sspd_pkg::PULSE_W:0]  diff_pos, diff_neg, diff_sel;
    logic [sspd_pkg::PULSE_W-1:0]       diff_abs;
    logic [sspd_pkg::MAG_W-1:0]         mag;
    logic [sspd_pkg::ELAPSED_W-1:0]     elapsed_inc;
    logic                               expire;
    logic signed [sspd_pkg::RAW_W-1:0]  map_raw;
    logic [sspd_pkg::PULSE_W-1:0]       map_clamped;
    logic [sspd_pkg::PULSE_W-1:0]       stop_clamped;
    logic [sspd_pkg::DUTY_W-1:0]        duty_sat;

    function automatic logic [sspd_pkg::PULSE_W-1:0] clamp_pulse(
        input logic signed [sspd_pkg::RAW_W-1:0] raw,
        input logic [sspd_pkg::PULSE_W-1:0]      lo,
        input logic [sspd_pkg::PULSE_W-1:0]      hi
    );
        logic [sspd_pkg::PULSE_W-1:0] result;
        if (raw < $signed({2'b00, lo}))
        begin
            result = lo;
        end
        else if (raw > $signed({2'b00, hi}))
        begin
            result = hi;
        end
        else
        begin
            result = raw[sspd_pkg::PULSE_W-1:0];
        end
        return result;
    endfunction

    assign cmd_fire = cmd.valid && cmd.ready;
    assign out_free = !out_valid_reg || res.ready;

    always_comb
    begin
        if (cmd.speed > sspd_pkg::SPEED_W'(sspd_pkg::SPEED_LIM))
        begin
            spd_clamped = sspd_pkg::SPEED_W'(sspd_pkg::SPEED_LIM);
        end
        else if (cmd.speed < -sspd_pkg::SPEED_W'(sspd_pkg::SPEED_LIM))
        begin
            spd_clamped = -sspd_pkg::SPEED_W'(sspd_pkg::SPEED_LIM);
        end
        else
        begin
            spd_clamped = cmd.speed;
        end
    end

    always_comb
    begin
        case (cmd.mode)
            sspd_pkg::MODE_RAISE: spd_eff = sspd_pkg::SPEED_W'(sspd_pkg::SPEED_LIM);
            sspd_pkg::MODE_LOWER: spd_eff = -sspd_pkg::SPEED_W'(sspd_pkg::SPEED_LIM);
            default:              spd_eff = spd_clamped;
        endcase
    end

    assign spd_pos   = (spd_eff > 0);
    assign spd_zero  = (spd_eff == 0);
    assign spd_shift = spd_eff + sspd_pkg::SPEED_W'(sspd_pkg::SPEED_LIM);
    assign diff_pos  = $signed({1'b0, max_reg}) - $signed({1'b0, stop_reg});
    assign diff_neg  = $signed({1'b0, stop_reg}) - $signed({1'b0, min_reg});
    assign diff_sel  = spd_pos ? diff_pos : diff_neg;
    assign diff_abs  = diff_sel[sspd_pkg::PULSE_W] ?
                       sspd_pkg::PULSE_W'(-diff_sel) : diff_sel[sspd_pkg::PULSE_W-1:0];
    assign mag       = spd_pos ? spd_eff[sspd_pkg::MAG_W-1:0] : spd_shift[sspd_pkg::MAG_W-1:0];

    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;
    assign expire      = (elapsed_inc >= sspd_pkg::MOVE_MS_CNT);

    assign map_raw = neg_reg ?
        $signed({2'b00, base_reg}) - $signed({2'b00, md_rsp.q[sspd_pkg::PULSE_W-1:0]}) :
        $signed({2'b00, base_reg}) + $signed({2'b00, md_rsp.q[sspd_pkg::PULSE_W-1:0]});
    assign map_clamped  = clamp_pulse(map_raw, min_reg, max_reg);
    assign stop_clamped = clamp_pulse($signed({2'b00, stop_reg}), min_reg, max_reg);
    assign duty_sat     = (|md_rsp.q[sspd_pkg::PROD_W-1:sspd_pkg::DUTY_W]) ?
                          '1 : md_rsp.q[sspd_pkg::DUTY_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sspd_pkg::ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    unique case (cmd.mode) inside
                        sspd_pkg::MODE_SET:
                        begin
                            state_next = spd_zero ? sspd_pkg::ST_DUTY_GO : sspd_pkg::ST_MAP_GO;
                        end
                        sspd_pkg::MODE_STOP:
                        begin
                            state_next = sspd_pkg::ST_DUTY_GO;
                        end
                        sspd_pkg::MODE_RAISE, sspd_pkg::MODE_LOWER:
                        begin
                            state_next = sspd_pkg::ST_MAP_GO;
                        end
                        sspd_pkg::MODE_TICK:
                        begin
                            if (armed_reg && expire)
                            begin
                                state_next = sspd_pkg::ST_DUTY_GO;
                            end
                        end
                        default:
                        begin
                            state_next = sspd_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            sspd_pkg::ST_MAP_GO:
            begin
                state_next = sspd_pkg::ST_MAP_WAIT;
            end
            sspd_pkg::ST_MAP_WAIT:
            begin
                if (md_rsp.done)
                begin
                    state_next = sspd_pkg::ST_DUTY_GO;
                end
            end
            sspd_pkg::ST_DUTY_GO:
            begin
                state_next = sspd_pkg::ST_DUTY_WAIT;
            end
            sspd_pkg::ST_DUTY_WAIT:
            begin
                if (md_rsp.done)
                begin
                    state_next = sspd_pkg::ST_EMIT;
                end
            end
            sspd_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = sspd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sspd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        armed_next      = armed_reg;
        elapsed_next    = elapsed_reg;
        opa_next        = opa_reg;
        opb_next        = opb_reg;
        use_period_next = use_period_reg;
        neg_next        = neg_reg;
        base_next       = base_reg;
        pulse_next      = pulse_reg;
        duty_next       = duty_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        out_duty_next   = out_duty_reg;
        out_pulse_next  = out_pulse_reg;
        out_active_next = out_active_reg;
        unique case (state_reg)
            sspd_pkg::ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    // stop pulse, clamped, feeding the duty pass directly
                    pulse_next      = stop_clamped;
                    opa_next        = stop_clamped;
                    opb_next        = sspd_pkg::B_W'(sspd_pkg::FULL_SCALE);
                    use_period_next = 1'b1;
                    if ((cmd.mode == sspd_pkg::MODE_RAISE) || (cmd.mode == sspd_pkg::MODE_LOWER))
                    begin
                        armed_next   = 1'b1;
                        elapsed_next = '0;
                    end
                    if (cmd.mode == sspd_pkg::MODE_TICK && armed_reg)
                    begin
                        elapsed_next = elapsed_inc;
                        if (expire)
                        begin
                            armed_next = 1'b0;
                        end
                    end
                    if ((cmd.mode == sspd_pkg::MODE_SET && !spd_zero) ||
                        (cmd.mode == sspd_pkg::MODE_RAISE) || (cmd.mode == sspd_pkg::MODE_LOWER))
                    begin
                        opa_next        = diff_abs;
                        opb_next        = sspd_pkg::B_W'(mag);
                        use_period_next = 1'b0;
                        neg_next        = diff_sel[sspd_pkg::PULSE_W];
                        base_next       = spd_pos ? stop_reg : min_reg;
                    end
                end
            end
            sspd_pkg::ST_MAP_WAIT:
            begin
                if (md_rsp.done)
                begin
                    pulse_next      = map_clamped;
                    opa_next        = map_clamped;
                    opb_next        = sspd_pkg::B_W'(sspd_pkg::FULL_SCALE);
                    use_period_next = 1'b1;
                end
            end
            sspd_pkg::ST_DUTY_WAIT:
            begin
                if (md_rsp.done)
                begin
                    duty_next = duty_sat;
                end
            end
            sspd_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_duty_next   = duty_reg;
                    out_pulse_next  = pulse_reg;
                    out_active_next = armed_reg;
                end
            end
            default:
            begin
                duty_next = duty_reg;
            end
        endcase
    end

    always_comb
    begin
        cmd.ready        = (state_reg == sspd_pkg::ST_IDLE);
        md_req.start     = (state_reg == sspd_pkg::ST_MAP_GO) ||
                           (state_reg == sspd_pkg::ST_DUTY_GO);
        md_req.a         = opa_reg;
        md_req.b         = opb_reg;
        md_req.d         = use_period_reg ? sspd_pkg::DIV_W'(sspd_pkg::PERIOD_US) :
                                            sspd_pkg::DIV_W'(sspd_pkg::MAP_DIV);
        res.valid        = out_valid_reg;
        res.duty         = out_duty_reg;
        res.pulse_us     = out_pulse_reg;
        res.timed_active = out_active_reg;
    end

    sspd_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_reg <= sspd_pkg::STOP_RESET;
            min_reg  <= sspd_pkg::MIN_RESET;
            max_reg  <= sspd_pkg::MAX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sspd_pkg::CFG_STOP: stop_reg <= cfg_data;
                sspd_pkg::CFG_MIN:  min_reg  <= cfg_data;
                sspd_pkg::CFG_MAX:  max_reg  <= cfg_data;
                default:            stop_reg <= stop_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sspd_pkg::ST_IDLE;
            armed_reg     <= 1'b0;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            armed_reg     <= armed_next;
            elapsed_reg   <= elapsed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opa_reg        <= opa_next;
        opb_reg        <= opb_next;
        use_period_reg <= use_period_next;
        neg_reg        <= neg_next;
        base_reg       <= base_next;
        pulse_reg      <= pulse_next;
        duty_reg       <= duty_next;
        out_duty_reg   <= out_duty_next;
        out_pulse_reg  <= out_pulse_next;
        out_active_reg <= out_active_next;
    end

    a_disarm_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(armed_reg) |-> ($past(state_reg) == sspd_pkg::ST_IDLE))
        else $error("timer disarmed outside a command transaction");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        md_rsp.done |-> ((state_reg == sspd_pkg::ST_MAP_WAIT) ||
                         (state_reg == sspd_pkg::ST_DUTY_WAIT)))
        else $error("muldiv result arrived while not waiting");

    a_timer_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != sspd_pkg::ST_IDLE) |=> ($stable(armed_reg) && $stable(elapsed_reg)))
        else $error("timer state changed while busy");

endmodule
